>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, ignored while aresetn is low.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, ignored while aresetn is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gpia_pkg.sv
// ----------------------------------------------------------------------------
// gpia_pkg
// Types, codes and widths shared by the pool index allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gpia_pkg;

    localparam int IDX_W       = 6;   // entry index width
    localparam int CNT_W       = 7;   // counts and config values
    localparam int ACT_W       = 2;
    localparam int ST_W        = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_ENTRIES = 64;

    localparam logic [CNT_W-1:0] RST_INITIAL_SIZE  = 7'd0;
    localparam logic [CNT_W-1:0] RST_MAX_POOL_SIZE = 7'd64;

    localparam logic [ACT_W-1:0] ACT_ACQUIRE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd2;

    localparam logic [ST_W-1:0] ST_GRANTED     = 3'd0;
    localparam logic [ST_W-1:0] ST_POOL_FULL   = 3'd1;
    localparam logic [ST_W-1:0] ST_RELEASED    = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_IN_POOL = 3'd3;
    localparam logic [ST_W-1:0] ST_DUPLICATE   = 3'd4;
    localparam logic [ST_W-1:0] ST_QUERY       = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POOL_SIZE = 2'd1;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] entry_index;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] active_count;
        logic [CNT_W-1:0] pool_count;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // register the accepted item, head read starts
        logic commit;   // apply the item and load the result register
    } gpia_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/gpia_ctrl.sv
// ----------------------------------------------------------------------------
// gpia_ctrl
// Handshake controller: sequences one item at a time and owns result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module gpia_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output gpia_pkg::gpia_cmd_t      cmd
);

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready     = (state_reg == IDLE);
    assign cmd.capture = s_valid && (state_reg == IDLE);
    // the result register must be free (or draining) before an item commits
    assign cmd.commit  = (state_reg == EXEC) && (!m_valid_reg || m_ready);
    assign m_valid     = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    state_next = EXEC;
                end
            end
            EXEC: begin
                if (cmd.commit) begin
                    state_next   = IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gpia_dp.sv
// ----------------------------------------------------------------------------
// gpia_dp
// Datapath: config registers, pool counters, free queue memory, free marks
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpia_dp #(
    parameter int MAX_ENTRIES = gpia_pkg::MAX_ENTRIES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire gpia_pkg::gpia_cmd_t              cmd,
    input  wire gpia_pkg::in_item_t               s_data,
    output gpia_pkg::out_item_t                   m_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [gpia_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gpia_pkg::CNT_W-1:0]       cfg_data
);

    localparam int CW     = gpia_pkg::CNT_W;
    localparam int IW     = gpia_pkg::IDX_W;
    localparam int PTR_W  = $clog2(MAX_ENTRIES);
    localparam int MARK_N = (MAX_ENTRIES < (1 << IW)) ? MAX_ENTRIES : (1 << IW);
    localparam int MARK_W = $clog2(MARK_N);
    localparam int MAXC   = (MAX_ENTRIES > (1 << CW) - 1) ? (1 << CW) - 1 : MAX_ENTRIES;
    localparam logic [CW-1:0]    MAX_CLIP = CW'(MAXC);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_ENTRIES - 1);

    // config
    logic [CW-1:0] init_size_reg;
    logic [CW-1:0] max_pool_reg;

    // allocator state
    logic [CW-1:0]    fresh_reg, fresh_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CW-1:0]    qcnt_reg, qcnt_next;
    logic [MARK_N-1:0] marks_reg;

    // free queue; entries are always written before their read value is used
    logic [IW-1:0] fq_mem [MAX_ENTRIES];
    logic [IW-1:0] rd_data_reg;

    gpia_pkg::in_item_t  item_reg;
    gpia_pkg::out_item_t out_reg;

    logic [CW-1:0]          eff_max, eff_init, pool_cur, pool_new, active_new;
    logic [CW-1:0]          idx_ext;
    logic [MARK_W-1:0]      idx_m;
    logic                   mem_we, mark_set, mark_clr;
    logic [IW-1:0]          granted;
    logic [gpia_pkg::ST_W-1:0] status;

    assign cfg_ready = 1'b1;
    assign m_data    = out_reg;

    assign eff_max  = (max_pool_reg < MAX_CLIP) ? max_pool_reg : MAX_CLIP;
    assign eff_init = (init_size_reg < eff_max) ? init_size_reg : eff_max;
    assign pool_cur = (fresh_reg > eff_init) ? fresh_reg : eff_init;
    assign idx_ext  = {1'b0, item_reg.entry_index};
    assign idx_m    = item_reg.entry_index[MARK_W-1:0];

    always_comb begin
        fresh_next = fresh_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        qcnt_next  = qcnt_reg;
        mem_we     = 1'b0;
        mark_set   = 1'b0;
        mark_clr   = 1'b0;
        granted    = '0;
        status     = gpia_pkg::ST_QUERY;
        case (item_reg.action)
            gpia_pkg::ACT_ACQUIRE: begin
                if (fresh_reg < eff_init) begin
                    granted    = fresh_reg[IW-1:0];
                    fresh_next = fresh_reg + 1'b1;
                    status     = gpia_pkg::ST_GRANTED;
                end else if (qcnt_reg != '0) begin
                    granted   = rd_data_reg;
                    head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                    qcnt_next = qcnt_reg - 1'b1;
                    mark_clr  = 1'b1;
                    status    = gpia_pkg::ST_GRANTED;
                end else if (fresh_reg < eff_max) begin
                    granted    = fresh_reg[IW-1:0];
                    fresh_next = fresh_reg + 1'b1;
                    status     = gpia_pkg::ST_GRANTED;
                end else begin
                    status = gpia_pkg::ST_POOL_FULL;
                end
            end
            gpia_pkg::ACT_RELEASE: begin
                if (idx_ext >= pool_cur || int'(item_reg.entry_index) >= MAX_ENTRIES) begin
                    status = gpia_pkg::ST_NOT_IN_POOL;
                end else if (marks_reg[idx_m] || idx_ext >= fresh_reg
                             || int'(qcnt_reg) >= MAX_ENTRIES) begin
                    // also catches initial indices that were never handed out
                    status = gpia_pkg::ST_DUPLICATE;
                end else begin
                    mem_we    = 1'b1;
                    mark_set  = 1'b1;
                    tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                    qcnt_next = qcnt_reg + 1'b1;
                    status    = gpia_pkg::ST_RELEASED;
                end
            end
            default: begin
                status = gpia_pkg::ST_QUERY;
            end
        endcase
    end

    assign pool_new   = (fresh_next > eff_init) ? fresh_next : eff_init;
    assign active_new = fresh_next - qcnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_size_reg <= gpia_pkg::RST_INITIAL_SIZE;
            max_pool_reg  <= gpia_pkg::RST_MAX_POOL_SIZE;
            fresh_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            qcnt_reg      <= '0;
            marks_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    gpia_pkg::CFG_INITIAL_SIZE:  init_size_reg <= cfg_data;
                    gpia_pkg::CFG_MAX_POOL_SIZE: max_pool_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.commit) begin
                fresh_reg <= fresh_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                qcnt_reg  <= qcnt_next;
                if (mark_set) begin
                    marks_reg[idx_m] <= 1'b1;
                end
                if (mark_clr) begin
                    marks_reg[rd_data_reg[MARK_W-1:0]] <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.commit) begin
            out_reg.granted_index <= granted;
            out_reg.status        <= status;
            out_reg.active_count  <= active_new;
            out_reg.pool_count    <= pool_new;
        end
    end

    // free queue memory: head is read every cycle; the read data is registered
    always_ff @(posedge aclk) begin
        if (cmd.commit && mem_we) begin
            fq_mem[tail_reg] <= item_reg.entry_index;
        end
        rd_data_reg <= fq_mem[head_reg];
    end

endmodule

`default_nettype wire

>>> hw/rtl/growable_pool_index_allocator_unit.sv
// ----------------------------------------------------------------------------
// growable_pool_index_allocator_unit
// Pool index allocator with a FIFO free list and a growable pool.
// ----------------------------------------------------------------------------
// Each item is first registered while the free queue head is read from its
// memory, then applied, which loads the result register; the registered read
// of the free-queue memory sets this split. s_ready stays low until the item
// commits, so a new item is accepted only after the last one is applied. A
// result waiting on m_ready does not stop the next item from being accepted;
// that item commits once the result register is taken. The free marks live
// in flops cleared by reset, so no clearing pass follows reset. The config
// port is always ready; write it only while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module growable_pool_index_allocator_unit #(
    parameter int MAX_ENTRIES = gpia_pkg::MAX_ENTRIES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire gpia_pkg::in_item_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output gpia_pkg::out_item_t                   m_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [gpia_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gpia_pkg::CNT_W-1:0]       cfg_data
);

    gpia_pkg::gpia_cmd_t cmd;

    gpia_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    gpia_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    `ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")
    `ASSERT_SAME(a_no_overwrite, cmd.commit, !m_valid || m_ready, "result overwritten")
    `ASSERT_SAME(a_grant_zero, m_valid && (m_data.status != gpia_pkg::ST_GRANTED),
                 m_data.granted_index == '0, "nonzero index without grant")
    `ASSERT_SAME(a_active_le_pool, m_valid, m_data.active_count <= m_data.pool_count,
                 "active count exceeds pool")

endmodule

`default_nettype wire
